@@ rtl/core/vpa_pkg.sv @@
// ----------------------------------------------------------------------------
// vpa_pkg
// shared types and constants of the variable partition allocator
// ----------------------------------------------------------------------------
package vpa_pkg;

  localparam int DEF_MEM_UNITS    = 1024;
  localparam int DEF_MAX_SEGMENTS = 64;
  localparam int OWNER_W          = 16;
  localparam int STATUS_W         = 3;
  localparam int POLICY_W         = 2;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_HELD     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOFIT    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
  localparam logic [POLICY_W-1:0] POL_NEXT  = 2'd1;
  localparam logic [POLICY_W-1:0] POL_BEST  = 2'd2;
  localparam logic [POLICY_W-1:0] POL_WORST = 2'd3;

  // operation broadcast to every cell of the segment row
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_ROTATE,
    CELL_SPLIT,
    CELL_TAKE,
    CELL_RELEASE,
    CELL_MERGE
  } cell_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_MERGE_HI,
    S_MERGE_LO,
    S_RESP
  } state_t;

endpackage

@@ rtl/core/vpa_req_if.sv @@
// ----------------------------------------------------------------------------
// vpa_req_if
// request channel: allocate or free
// ----------------------------------------------------------------------------
interface vpa_req_if #(
  parameter int LEN_W = 11
);
  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic [vpa_pkg::OWNER_W-1:0] owner_id;
  logic [LEN_W-1:0]          req_size;

  modport source (output valid, req_type, owner_id, req_size, input ready);
  modport sink   (input valid, req_type, owner_id, req_size, output ready);
endinterface

@@ rtl/core/vpa_resp_if.sv @@
// ----------------------------------------------------------------------------
// vpa_resp_if
// response channel: one result per request
// ----------------------------------------------------------------------------
interface vpa_resp_if #(
  parameter int START_W = 10
);
  logic                         valid;
  logic                         ready;
  logic                         ok;
  logic [START_W-1:0]           region_start;
  logic [vpa_pkg::STATUS_W-1:0] status;

  modport source (output valid, ok, region_start, status, input ready);
  modport sink   (input valid, ok, region_start, status, output ready);
endinterface

@@ rtl/core/vpa_cfg_if.sv @@
// ----------------------------------------------------------------------------
// vpa_cfg_if
// configuration write channel for the fit policy register
// ----------------------------------------------------------------------------
interface vpa_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [vpa_pkg::POLICY_W-1:0] fit_policy;

  modport source (output valid, fit_policy, input ready);
  modport sink   (input valid, fit_policy, output ready);
endinterface

@@ rtl/core/variable_partition_allocator_core.sv @@
// ----------------------------------------------------------------------------
// variable_partition_allocator_core
// segment table allocator with first, next, best and worst fit
// ----------------------------------------------------------------------------
// sequence: after the request transfer, a full scan of the table, then the decide
//   step, then for a successful free the merges with the follower and (unless the
//   released segment is entry zero) the predecessor, then the response register
// throughput: one request at a time, the next one taken the cycle after the
//   response is loaded; set by the full rotation of the cell ring, one segment
//   past the head cell each cycle, and held off while the output is full
// reset: synchronous; table holds one free segment covering all of memory,
//   fit policy first fit, next-fit pointer at segment zero
module variable_partition_allocator_core #(
  parameter int MEM_UNITS    = vpa_pkg::DEF_MEM_UNITS,
  parameter int MAX_SEGMENTS = vpa_pkg::DEF_MAX_SEGMENTS
) (
  input logic         clk,
  input logic         rst,
  vpa_cfg_if.sink     cfg,
  vpa_req_if.sink     req,
  vpa_resp_if.source  resp
);
  import vpa_pkg::*;

  localparam int START_W = $clog2(MEM_UNITS);
  localparam int LEN_W   = $clog2(MEM_UNITS + 1);
  localparam int IDX_W   = $clog2(MAX_SEGMENTS);
  localparam int SEG_W   = START_W + LEN_W + 1 + OWNER_W;
  localparam logic [IDX_W-1:0] LAST  = IDX_W'(MAX_SEGMENTS - 1);
  localparam logic [IDX_W:0]   FULLC = (IDX_W+1)'(MAX_SEGMENTS);

  state_t state, state_next;

  logic [POLICY_W-1:0] policy;
  logic [IDX_W:0]      count, count_next;
  logic [IDX_W-1:0]    rover, rover_next;
  logic [IDX_W-1:0]    k;
  logic [IDX_W-1:0]    r_eff;

  // latched request
  logic               typ_q;
  logic [OWNER_W-1:0] id_q;
  logic [LEN_W-1:0]   size_q;

  // scan results
  logic               held;
  logic [IDX_W-1:0]   hit_idx;
  logic               found_a, found_b;
  logic [IDX_W-1:0]   pick_a, pick_b;
  logic [LEN_W-1:0]   len_a, len_b;
  logic [START_W-1:0] start_a, start_b;

  // pending result and output register
  logic [STATUS_W-1:0] pend_status, pend_status_next;
  logic [START_W-1:0]  pend_start, pend_start_next;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [START_W-1:0]  out_start;

  // cell row control
  cell_op_t           op;
  logic [IDX_W-1:0]   tgt;
  logic               merge_any;
  logic [SEG_W-1:0]   seg_q [MAX_SEGMENTS];
  logic [MAX_SEGMENTS-1:0] mh;

  // head cell view
  logic [START_W-1:0] h_start;
  logic [LEN_W-1:0]   h_len;
  logic               h_free;
  logic [OWNER_W-1:0] h_owner;
  logic               h_valid, h_cand, h_match;

  // selected candidate: next fit prefers segments after the pointer
  logic               sel_found;
  logic [IDX_W-1:0]   sel_pick;
  logic [LEN_W-1:0]   sel_len;
  logic [START_W-1:0] sel_start;

  logic req_xfer, resp_load;

  assign cfg.ready = 1'b1;
  assign req.ready = (state == S_IDLE);
  assign req_xfer  = req.valid && req.ready;

  assign resp.valid        = out_valid;
  assign resp.ok           = (out_status == ST_OK);
  assign resp.region_start = out_start;
  assign resp.status       = out_status;

  // ring of cells, cell zero is the scan head
  for (genvar i = 0; i < MAX_SEGMENTS; i++) begin : g_cell
    vpa_cell #(
      .IDX(i), .MEM_UNITS(MEM_UNITS), .START_W(START_W),
      .LEN_W(LEN_W), .IDX_W(IDX_W), .SEG_W(SEG_W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .op        (op),
      .tgt       (tgt),
      .count     (count),
      .size      (size_q),
      .id        (id_q),
      .sp_start  (sel_start + START_W'(size_q)),
      .sp_len    (sel_len - size_q),
      .merge_any (merge_any),
      .left_seg  (seg_q[(i == 0) ? 0 : i - 1]),
      .right_seg (seg_q[(i + 1) % MAX_SEGMENTS]),
      .seg       (seg_q[i]),
      .merge_here(mh[i])
    );
  end

  assign merge_any = (op == CELL_MERGE) && (|mh);

  assign {h_start, h_len, h_free, h_owner} = seg_q[0];
  assign h_valid = ({1'b0, k} < count);
  assign h_cand  = h_valid && h_free && (size_q != '0) && (h_len >= size_q);
  assign h_match = h_valid && !h_free && (h_owner == id_q);

  assign sel_found = found_a || found_b;
  assign sel_pick  = found_a ? pick_a  : pick_b;
  assign sel_len   = found_a ? len_a   : len_b;
  assign sel_start = found_a ? start_a : start_b;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      policy <= POL_FIRST;
    end else if (cfg.valid && cfg.ready) begin
      policy <= cfg.fit_policy;
    end
  end

  // scan bookkeeping
  always_ff @(posedge clk) begin
    if (req_xfer) begin
      typ_q   <= req.req_type;
      id_q    <= req.owner_id;
      size_q  <= req.req_size;
      r_eff   <= ({1'b0, rover} < count) ? rover : '0;
      k       <= '0;
      held    <= 1'b0;
      found_a <= 1'b0;
      found_b <= 1'b0;
    end else if (state == S_SCAN) begin
      k <= k + 1'b1;
      if (h_match && !held) begin
        held    <= 1'b1;
        hit_idx <= k;
      end
      if (h_cand) begin
        if (policy == POL_NEXT) begin
          // wrap order: after the pointer first, then from the bottom
          if (k > r_eff) begin
            if (!found_a) begin
              found_a <= 1'b1;
              pick_a  <= k;
              len_a   <= h_len;
              start_a <= h_start;
            end
          end else if (!found_b) begin
            found_b <= 1'b1;
            pick_b  <= k;
            len_b   <= h_len;
            start_b <= h_start;
          end
        end else if (!found_b ||
                     (policy == POL_BEST  && h_len < len_b) ||
                     (policy == POL_WORST && h_len > len_b)) begin
          found_b <= 1'b1;
          pick_b  <= k;
          len_b   <= h_len;
          start_b <= h_start;
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= (IDX_W+1)'(1);
      rover     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      rover <= rover_next;
      if (resp_load) begin
        out_valid <= 1'b1;
      end else if (resp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_status <= pend_status_next;
    pend_start  <= pend_start_next;
    if (resp_load) begin
      out_status <= pend_status;
      out_start  <= pend_start;
    end
  end

  always_comb begin
    state_next       = state;
    count_next       = count;
    rover_next       = rover;
    pend_status_next = pend_status;
    pend_start_next  = pend_start;
    op               = CELL_HOLD;
    tgt              = hit_idx;
    resp_load        = 1'b0;
    case (state)
      S_IDLE: begin
        if (req_xfer) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        op = CELL_ROTATE;
        if (k == LAST) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        pend_start_next = '0;
        state_next      = S_RESP;
        if (typ_q == REQ_ALLOC) begin
          tgt = sel_pick;
          if (held) begin
            pend_status_next = ST_HELD;
          end else if (!sel_found) begin
            pend_status_next = ST_NOFIT;
            rover_next       = '0;
          end else if (sel_len > size_q) begin
            if (count == FULLC) begin
              pend_status_next = ST_FULL;
              rover_next       = '0;
            end else begin
              op               = CELL_SPLIT;
              count_next       = count + 1'b1;
              rover_next       = sel_pick;
              pend_status_next = ST_OK;
              pend_start_next  = sel_start;
            end
          end else begin
            op               = CELL_TAKE;
            rover_next       = sel_pick;
            pend_status_next = ST_OK;
            pend_start_next  = sel_start;
          end
        end else if (held) begin
          op               = CELL_RELEASE;
          rover_next       = '0;
          pend_status_next = ST_OK;
          state_next       = S_MERGE_HI;
        end else begin
          pend_status_next = ST_NOTFOUND;
        end
      end
      S_MERGE_HI: begin
        // join the released segment with a free follower
        op = CELL_MERGE;
        if (merge_any) begin
          count_next = count - 1'b1;
        end
        state_next = (hit_idx == '0) ? S_RESP : S_MERGE_LO;
      end
      S_MERGE_LO: begin
        // join a free predecessor with the released segment
        op  = CELL_MERGE;
        tgt = hit_idx - 1'b1;
        if (merge_any) begin
          count_next = count - 1'b1;
        end
        state_next = S_RESP;
      end
      S_RESP: begin
        if (!out_valid || resp.ready) begin
          resp_load  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/core/vpa_cell.sv @@
// ----------------------------------------------------------------------------
// vpa_cell
// one segment table entry, exchanging its contents with its neighbors
// ----------------------------------------------------------------------------
module vpa_cell #(
  parameter int IDX       = 0,
  parameter int MEM_UNITS = 1024,
  parameter int START_W   = 10,
  parameter int LEN_W     = 11,
  parameter int IDX_W     = 6,
  parameter int SEG_W     = START_W + LEN_W + 1 + vpa_pkg::OWNER_W
) (
  input  logic                        clk,
  input  logic                        rst,
  input  vpa_pkg::cell_op_t           op,
  input  logic [IDX_W-1:0]            tgt,
  input  logic [IDX_W:0]              count,
  input  logic [LEN_W-1:0]            size,
  input  logic [vpa_pkg::OWNER_W-1:0] id,
  input  logic [START_W-1:0]          sp_start,
  input  logic [LEN_W-1:0]            sp_len,
  input  logic                        merge_any,
  input  logic [SEG_W-1:0]            left_seg,
  input  logic [SEG_W-1:0]            right_seg,
  output logic [SEG_W-1:0]            seg,
  output logic                        merge_here
);
  import vpa_pkg::*;

  localparam logic [IDX_W:0] MY = (IDX_W+1)'(IDX);

  logic [START_W-1:0] start, start_next;
  logic [LEN_W-1:0]   len, len_next;
  logic               free, free_next;
  logic [OWNER_W-1:0] owner, owner_next;
  logic [IDX_W:0]     tgt_x;
  logic [LEN_W-1:0]   right_len;
  logic               right_free;

  assign tgt_x      = {1'b0, tgt};
  assign seg        = {start, len, free, owner};
  assign right_len  = right_seg[OWNER_W+1 +: LEN_W];
  assign right_free = right_seg[OWNER_W];
  assign merge_here = (tgt_x == MY) && free && right_free && ((MY + 1'b1) < count);

  always_comb begin
    {start_next, len_next, free_next, owner_next} = seg;
    case (op)
      CELL_ROTATE: begin
        {start_next, len_next, free_next, owner_next} = right_seg;
      end
      CELL_SPLIT: begin
        if (tgt_x == MY) begin
          len_next   = size;
          free_next  = 1'b0;
          owner_next = id;
        end else if (tgt_x + 1'b1 == MY) begin
          start_next = sp_start;
          len_next   = sp_len;
          free_next  = 1'b1;
          owner_next = '0;
        end else if (MY > tgt_x + 1'b1) begin
          {start_next, len_next, free_next, owner_next} = left_seg;
        end
      end
      CELL_TAKE: begin
        if (tgt_x == MY) begin
          len_next   = size;
          free_next  = 1'b0;
          owner_next = id;
        end
      end
      CELL_RELEASE: begin
        if (tgt_x == MY) begin
          free_next  = 1'b1;
          owner_next = '0;
        end
      end
      CELL_MERGE: begin
        if (merge_any) begin
          if (tgt_x == MY) begin
            len_next = len + right_len;
          end else if (MY > tgt_x) begin
            {start_next, len_next, free_next, owner_next} = right_seg;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start <= '0;
      len   <= (IDX == 0) ? LEN_W'(MEM_UNITS) : '0;
      free  <= (IDX == 0);
    end else begin
      start <= start_next;
      len   <= len_next;
      free  <= free_next;
    end
  end

  always_ff @(posedge clk) begin
    owner <= owner_next;
  end

endmodule
